FILE: rtl/core/knps_pkg.sv
// Shared types and constants for the k-nearest point selector.
// Depends on nothing; used by the controller, the datapath and the top level.
package knps_pkg;

    // Fixed widths of the result fields and of the configuration register, and its reset value.
    localparam int INDEX_BITS    = 16;
    localparam int DIST_OUT_BITS = 52;
    localparam int COUNT_BITS    = 5;
    localparam int COUNT_RESET   = 4;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_NEIGHBORS = 16;
    localparam int DEF_MAX_POINTS    = 65536;
    localparam int DEF_COORD_BITS    = 24;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic update;
        logic scan_start;
        logic scan_step;
        logic emit_start;
        logic emit_read;
        logic emit_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic replace;
        logic scan_done;
        logic emit_empty;
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/core/knps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module knps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/knps_ctrl.sv
// Sequencing state machine of the k-nearest point selector.
// Depends on knps_pkg for the command and status structs.
module knps_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pt_valid,
    output logic                  o_pt_stall,
    output knps_pkg::t_dp_cmd     o_cmd,
    input  knps_pkg::t_dp_status  i_status
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIFF      = 4'd1;
    localparam logic [3:0] S_SQ        = 4'd2;
    localparam logic [3:0] S_SUM       = 4'd3;
    localparam logic [3:0] S_UPD       = 4'd4;
    localparam logic [3:0] S_SCAN      = 4'd5;
    localparam logic [3:0] S_EMIT_INIT = 4'd6;
    localparam logic [3:0] S_EMIT_RD   = 4'd7;
    localparam logic [3:0] S_EMIT_LOAD = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_pt_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DIFF;
                end
            end
            S_DIFF: begin
                n_state = S_SQ;
            end
            S_SQ: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                if (i_status.replace) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_status.last) begin
                    n_state = S_EMIT_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = i_status.last ? S_EMIT_INIT : S_IDLE;
                end
            end
            S_EMIT_INIT: begin
                o_cmd.emit_start = 1'b1;
                n_state          = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                if (i_status.emit_empty) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit_read = 1'b1;
                    n_state         = S_EMIT_LOAD;
                end
            end
            S_EMIT_LOAD: begin
                o_cmd.emit_load = 1'b1;
                n_state         = i_status.emit_last ? S_IDLE : S_EMIT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_pt_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/core/knps_dp.sv
// Datapath of the k-nearest point selector: distance pipeline, slot bookkeeping,
// maximum rescan and result register. Depends on knps_pkg; the slot RAM is outside.
module knps_dp #(
    parameter int MAX_NEIGHBORS = knps_pkg::DEF_MAX_NEIGHBORS,
    parameter int MAX_POINTS    = knps_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS    = knps_pkg::DEF_COORD_BITS,
    localparam int SW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
    localparam int DW = 2 * COORD_BITS + 1,
    localparam int RW = knps_pkg::INDEX_BITS + DW
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [knps_pkg::COUNT_BITS-1:0]      i_neighbor_count,
    input  logic signed [COORD_BITS-1:0]         i_point_x,
    input  logic signed [COORD_BITS-1:0]         i_point_y,
    input  logic signed [COORD_BITS-1:0]         i_cell_x,
    input  logic signed [COORD_BITS-1:0]         i_cell_y,
    input  logic                                 i_first_point,
    input  logic                                 i_last_point,
    input  knps_pkg::t_dp_cmd                    i_cmd,
    output knps_pkg::t_dp_status                 o_status,
    output logic                                 o_ram_wr_en,
    output logic [SW-1:0]                        o_ram_wr_addr,
    output logic [RW-1:0]                        o_ram_wr_data,
    output logic                                 o_ram_rd_en,
    output logic [SW-1:0]                        o_ram_rd_addr,
    input  logic [RW-1:0]                        i_ram_rd_data,
    output logic                                 o_nb_valid,
    input  logic                                 i_nb_stall,
    output logic [knps_pkg::INDEX_BITS-1:0]      o_neighbor_index,
    output logic [knps_pkg::DIST_OUT_BITS-1:0]   o_neighbor_dist_sq,
    output logic                                 o_last_of_run
);

    localparam int CB      = COORD_BITS;
    localparam int KW      = $clog2(MAX_NEIGHBORS + 1);
    localparam int PW      = $clog2(MAX_POINTS + 1);
    localparam int CW      = (PW > KW) ? PW : KW;
    localparam int NW      = (KW > knps_pkg::COUNT_BITS) ? KW : knps_pkg::COUNT_BITS;
    localparam int IB      = knps_pkg::INDEX_BITS;
    localparam int OB      = knps_pkg::DIST_OUT_BITS;
    localparam int K_RESET = (knps_pkg::COUNT_RESET > MAX_NEIGHBORS) ?
                             MAX_NEIGHBORS : knps_pkg::COUNT_RESET;

    // Configuration and per-run state.
    logic [knps_pkg::COUNT_BITS-1:0] r_neighbor_count, n_neighbor_count;
    logic [KW-1:0]                   r_run_k, n_run_k;
    logic signed [CB-1:0]            r_qx, n_qx, r_qy, n_qy;
    logic [PW-1:0]                   r_points_seen, n_points_seen;
    logic [DW-1:0]                   r_max_dist, n_max_dist;
    logic [SW-1:0]                   r_max_slot, n_max_slot;

    // Current point and distance pipeline.
    logic signed [CB-1:0]            r_px, n_px, r_py, n_py;
    logic                            r_last, n_last;
    logic [CB-1:0]                   r_dx, n_dx, r_dy, n_dy;
    logic [2*CB-1:0]                 r_sqx, n_sqx, r_sqy, n_sqy;
    logic [DW-1:0]                   r_dist, n_dist;

    // Rescan and emission sequencing.
    logic [KW-1:0]                   r_scan_ptr, n_scan_ptr;
    logic                            r_scan_cmp_valid, n_scan_cmp_valid;
    logic [SW-1:0]                   r_scan_cmp_slot, n_scan_cmp_slot;
    logic [KW-1:0]                   r_emit_cnt, n_emit_cnt;
    logic [KW-1:0]                   r_emit_ptr, n_emit_ptr;

    // Result register.
    logic                            r_out_valid, n_out_valid;
    logic [IB-1:0]                   r_out_idx, n_out_idx;
    logic [OB-1:0]                   r_out_dist, n_out_dist;
    logic                            r_out_last, n_out_last;

    logic signed [CB:0]              diff_x, diff_y;
    logic [CB:0]                     neg_x, neg_y;
    logic [NW-1:0]                   cnt_c;
    logic [KW-1:0]                   k_clamped;
    logic [CW-1:0]                   ps_c, k_c;
    logic                            active, filling, replace;
    logic [KW-1:0]                   filled;
    logic [PW+IB-1:0]                ps_idx_ext;
    logic [IB-1:0]                   rd_idx;
    logic [DW-1:0]                   rd_dist;
    logic [DW+OB-1:0]                rd_dist_ext;
    logic                            scan_rd, scan_done, emit_last;

    // Absolute coordinate differences, squares and sum, one register level each.
    assign diff_x = {r_px[CB-1], r_px} - {r_qx[CB-1], r_qx};
    assign diff_y = {r_py[CB-1], r_py} - {r_qy[CB-1], r_qy};
    assign neg_x  = -diff_x;
    assign neg_y  = -diff_y;
    assign n_dx   = diff_x[CB] ? neg_x[CB-1:0] : diff_x[CB-1:0];
    assign n_dy   = diff_y[CB] ? neg_y[CB-1:0] : diff_y[CB-1:0];
    assign n_sqx  = r_dx * r_dx;
    assign n_sqy  = r_dy * r_dy;
    assign n_dist = DW'(r_sqx) + DW'(r_sqy);

    // A count of zero keeps one point; a count above the slot depth is capped.
    assign cnt_c = NW'(r_neighbor_count);
    always_comb begin
        if (cnt_c == '0) begin
            k_clamped = KW'(1);
        end else if (cnt_c > NW'(MAX_NEIGHBORS)) begin
            k_clamped = KW'(MAX_NEIGHBORS);
        end else begin
            k_clamped = cnt_c[KW-1:0];
        end
    end

    assign ps_c       = CW'(r_points_seen);
    assign k_c        = CW'(r_run_k);
    assign active     = r_points_seen < PW'(MAX_POINTS);
    assign filling    = ps_c < k_c;
    assign replace    = active && !filling && (r_dist < r_max_dist);
    assign filled     = filling ? ps_c[KW-1:0] : r_run_k;
    assign ps_idx_ext = {{IB{1'b0}}, r_points_seen};

    assign rd_idx      = i_ram_rd_data[RW-1:DW];
    assign rd_dist     = i_ram_rd_data[DW-1:0];
    assign rd_dist_ext = {{OB{1'b0}}, rd_dist};

    assign scan_rd   = i_cmd.scan_step && (r_scan_ptr < r_run_k);
    assign scan_done = i_cmd.scan_step && r_scan_cmp_valid &&
                       (KW'(r_scan_cmp_slot) == (r_run_k - KW'(1)));
    assign emit_last = (r_emit_ptr == (r_emit_cnt - KW'(1)));

    // Slot RAM ports.
    assign o_ram_wr_en   = i_cmd.update && ((active && filling) || replace);
    assign o_ram_wr_addr = filling ? ps_c[SW-1:0] : r_max_slot;
    assign o_ram_wr_data = {ps_idx_ext[IB-1:0], r_dist};
    assign o_ram_rd_en   = i_cmd.emit_read || scan_rd;
    assign o_ram_rd_addr = i_cmd.emit_read ? r_emit_ptr[SW-1:0] : r_scan_ptr[SW-1:0];

    always_comb begin
        n_neighbor_count = r_neighbor_count;
        n_run_k          = r_run_k;
        n_qx             = r_qx;
        n_qy             = r_qy;
        n_points_seen    = r_points_seen;
        n_max_dist       = r_max_dist;
        n_max_slot       = r_max_slot;
        n_px             = r_px;
        n_py             = r_py;
        n_last           = r_last;
        n_scan_ptr       = r_scan_ptr;
        n_scan_cmp_valid = r_scan_cmp_valid;
        n_scan_cmp_slot  = r_scan_cmp_slot;
        n_emit_cnt       = r_emit_cnt;
        n_emit_ptr       = r_emit_ptr;
        n_out_valid      = r_out_valid;
        n_out_idx        = r_out_idx;
        n_out_dist       = r_out_dist;
        n_out_last       = r_out_last;

        if (i_cfg_we) begin
            n_neighbor_count = i_neighbor_count;
        end

        if (i_cmd.accept) begin
            n_px   = i_point_x;
            n_py   = i_point_y;
            n_last = i_last_point;
            if (i_first_point) begin
                n_qx          = i_cell_x;
                n_qy          = i_cell_y;
                n_run_k       = k_clamped;
                n_points_seen = '0;
                n_max_dist    = '0;
                n_max_slot    = '0;
            end
        end

        if (i_cmd.update && active) begin
            if (filling && (r_dist > r_max_dist)) begin
                n_max_dist = r_dist;
                n_max_slot = ps_c[SW-1:0];
            end
            n_points_seen = r_points_seen + PW'(1);
        end

        if (i_cmd.scan_start) begin
            n_scan_ptr       = '0;
            n_scan_cmp_valid = 1'b0;
        end

        // Rescan: one slot read per cycle, each compared in the cycle after its read.
        // The lowest slot wins ties because only a strictly larger value moves it.
        if (i_cmd.scan_step) begin
            if (scan_rd) begin
                n_scan_ptr = r_scan_ptr + KW'(1);
            end
            n_scan_cmp_valid = scan_rd;
            n_scan_cmp_slot  = r_scan_ptr[SW-1:0];
            if (r_scan_cmp_valid &&
                ((r_scan_cmp_slot == '0) || (rd_dist > r_max_dist))) begin
                n_max_dist = rd_dist;
                n_max_slot = r_scan_cmp_slot;
            end
        end

        if (i_cmd.emit_start) begin
            n_emit_cnt    = filled;
            n_emit_ptr    = '0;
            n_points_seen = '0;
            n_max_dist    = '0;
            n_max_slot    = '0;
        end

        if (i_cmd.emit_load) begin
            n_out_valid = 1'b1;
            n_out_idx   = rd_idx;
            n_out_dist  = rd_dist_ext[OB-1:0];
            n_out_last  = emit_last;
            n_emit_ptr  = r_emit_ptr + KW'(1);
        end else if (!i_nb_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor_count <= knps_pkg::COUNT_BITS'(knps_pkg::COUNT_RESET);
            r_run_k          <= KW'(K_RESET);
            r_qx             <= '0;
            r_qy             <= '0;
            r_points_seen    <= '0;
            r_max_dist       <= '0;
            r_max_slot       <= '0;
            r_scan_ptr       <= '0;
            r_scan_cmp_valid <= 1'b0;
            r_emit_cnt       <= '0;
            r_emit_ptr       <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_neighbor_count <= n_neighbor_count;
            r_run_k          <= n_run_k;
            r_qx             <= n_qx;
            r_qy             <= n_qy;
            r_points_seen    <= n_points_seen;
            r_max_dist       <= n_max_dist;
            r_max_slot       <= n_max_slot;
            r_scan_ptr       <= n_scan_ptr;
            r_scan_cmp_valid <= n_scan_cmp_valid;
            r_emit_cnt       <= n_emit_cnt;
            r_emit_ptr       <= n_emit_ptr;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px            <= n_px;
        r_py            <= n_py;
        r_last          <= n_last;
        r_dx            <= n_dx;
        r_dy            <= n_dy;
        r_sqx           <= n_sqx;
        r_sqy           <= n_sqy;
        r_dist          <= n_dist;
        r_scan_cmp_slot <= n_scan_cmp_slot;
        r_out_idx       <= n_out_idx;
        r_out_dist      <= n_out_dist;
        r_out_last      <= n_out_last;
    end

    assign o_status.last       = r_last;
    assign o_status.replace    = replace;
    assign o_status.scan_done  = scan_done;
    assign o_status.emit_empty = (r_emit_cnt == '0);
    assign o_status.emit_last  = emit_last;
    assign o_status.out_free   = !r_out_valid || !i_nb_stall;

    assign o_nb_valid         = r_out_valid;
    assign o_neighbor_index   = r_out_idx;
    assign o_neighbor_dist_sq = r_out_dist;
    assign o_last_of_run      = r_out_last;

endmodule

FILE: rtl/core/k_nearest_point_select.sv
// Top level of the k-nearest point selector: controller, datapath and slot RAM.
// Depends on knps_pkg, knps_ctrl, knps_dp and knps_ram.
//
// Usage. Points arrive on the point channel (i_pt_valid / o_pt_stall); a request
// is taken on a rising edge with valid high and stall low. The point that carries
// i_first_point latches the query cell and the neighbor count k and clears the
// slots. The point that carries i_last_point ends the run, and the kept neighbors
// leave on the result channel (o_nb_valid / i_nb_stall) in slot order, the last
// one flagged by o_last_of_run. The neighbor count must be written on the config
// channel (i_cfg_valid / o_cfg_ready) while idle (unchecked); ready is always high.
//
// Throughput. A point passes through the distance pipeline (difference, square,
// sum, slot update) before the next point is taken. A point that replaces the
// farthest slot adds a rescan of all k slots of the slot RAM, one slot read per
// cycle through its registered read port. After a last point and any rescan,
// emission starts; each result then takes one RAM read and a register load.
// A stalled result holds in the output register; emission pauses until it is
// taken, but the last result of a run never blocks the next point.
// Reset (synchronous, active low) clears control state, sets k to 4 and the
// query cell to the origin; the slot RAM needs no clearing.
module k_nearest_point_select #(
    parameter int MAX_NEIGHBORS = knps_pkg::DEF_MAX_NEIGHBORS,
    parameter int MAX_POINTS    = knps_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS    = knps_pkg::DEF_COORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [knps_pkg::COUNT_BITS-1:0]      i_neighbor_count,
    // Point channel.
    input  logic                                 i_pt_valid,
    output logic                                 o_pt_stall,
    input  logic signed [COORD_BITS-1:0]         i_point_x,
    input  logic signed [COORD_BITS-1:0]         i_point_y,
    input  logic signed [COORD_BITS-1:0]         i_cell_x,
    input  logic signed [COORD_BITS-1:0]         i_cell_y,
    input  logic                                 i_first_point,
    input  logic                                 i_last_point,
    // Result channel.
    output logic                                 o_nb_valid,
    input  logic                                 i_nb_stall,
    output logic [knps_pkg::INDEX_BITS-1:0]      o_neighbor_index,
    output logic [knps_pkg::DIST_OUT_BITS-1:0]   o_neighbor_dist_sq,
    output logic                                 o_last_of_run
);

    localparam int SW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int RW = knps_pkg::INDEX_BITS + DW;

    knps_pkg::t_dp_cmd    cmd;
    knps_pkg::t_dp_status status;

    logic          cfg_we;
    logic          ram_wr_en;
    logic [SW-1:0] ram_wr_addr;
    logic [RW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [SW-1:0] ram_rd_addr;
    logic [RW-1:0] ram_rd_data;

    // Configuration writes must come only while idle; unchecked, all are accepted.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    knps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt_valid (i_pt_valid),
        .o_pt_stall (o_pt_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    knps_dp #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .MAX_POINTS    (MAX_POINTS),
        .COORD_BITS    (COORD_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_neighbor_count   (i_neighbor_count),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_cell_x           (i_cell_x),
        .i_cell_y           (i_cell_y),
        .i_first_point      (i_first_point),
        .i_last_point       (i_last_point),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_ram_wr_en        (ram_wr_en),
        .o_ram_wr_addr      (ram_wr_addr),
        .o_ram_wr_data      (ram_wr_data),
        .o_ram_rd_en        (ram_rd_en),
        .o_ram_rd_addr      (ram_rd_addr),
        .i_ram_rd_data      (ram_rd_data),
        .o_nb_valid         (o_nb_valid),
        .i_nb_stall         (i_nb_stall),
        .o_neighbor_index   (o_neighbor_index),
        .o_neighbor_dist_sq (o_neighbor_dist_sq),
        .o_last_of_run      (o_last_of_run)
    );

    // Slot store: point index and squared distance of each kept neighbor.
    knps_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_NEIGHBORS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule
